// ----- sv/mwsm_pkg.sv -----
// Shared types and constants for the moving window sum and mean core.
// Used by every module of the block except mwsm_ram; depends on nothing else.
package mwsm_pkg;

	localparam int MAX_WINDOW  = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 8;
	localparam int MEAN_W      = 24;

	localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = SAMPLE_BITS + PTR_W;
	localparam int DIVD_W = SUM_W + FRAC_BITS;
	localparam int STEP_W = $clog2(DIVD_W);

	localparam int RES_W      = SUM_W + CNT_W + MEAN_W;
	localparam int S_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W  = ((RES_W + 7) / 8) * 8;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [SUM_W-1:0]       sum_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [PTR_W-1:0]       ptr_t;
	typedef logic [MEAN_W-1:0]      mean_t;
	typedef logic [DIVD_W-1:0]      divd_t;

	// Work handed from the ring update to the divider.
	typedef struct packed {
		sum_t sum;
		cnt_t count;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} push_t;

	// Packed so that the sum sits in the lowest bits.
	typedef struct packed {
		mean_t mean;
		cnt_t  count;
		sum_t  sum;
	} result_t;

	typedef enum logic {
		F_IDLE,
		F_UPDATE
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIVIDE,
		B_HOLD
	} back_state_t;

endpackage

// ----- sv/mwsm_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; no package needed.
module mwsm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/mwsm_front.sv -----
// Front part: takes samples, keeps the sample ring, running sum and fill count.
// Depends on mwsm_pkg and mwsm_ram; hands (sum, count) jobs to the queue.
module mwsm_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [mwsm_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mwsm_pkg::CNT_W-1:0]       cfg_data,
	output mwsm_pkg::push_t                  push,
	input  logic                             q_full
);
	import mwsm_pkg::*;

	front_state_t state_q, state_d;
	cnt_t         wl_q, wl_d;
	ptr_t         wpos_q, next_pos;
	cnt_t         fill_q, new_fill;
	sum_t         sum_q, new_sum;
	sample_t      sample_q, old_sample, ring_rdata;
	logic         ram_we;

	mwsm_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wpos_q),
		.wdata(sample_q),
		.raddr(wpos_q),
		.rdata(ring_rdata)
	);

	assign cfg_ready = 1'b1;

	always_comb begin
		if (cfg_data == '0) begin
			wl_d = cnt_t'(1);
		end else if (cfg_data > cnt_t'(MAX_WINDOW)) begin
			wl_d = cnt_t'(MAX_WINDOW);
		end else begin
			wl_d = cfg_data;
		end
	end

	// Until the window has filled once, the slot being replaced was never
	// written since the last clear and counts as zero.
	always_comb begin
		old_sample = (fill_q == wl_q) ? ring_rdata : '0;
		new_sum    = sum_q + sum_t'(sample_q) - sum_t'(old_sample);
		new_fill   = (fill_q < wl_q) ? fill_q + cnt_t'(1) : fill_q;
		next_pos   = (wpos_q == '0) ? ptr_t'(wl_q - cnt_t'(1)) : wpos_q - ptr_t'(1);
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		ram_we     = 1'b0;
		push.valid = 1'b0;
		push.job   = '{sum: new_sum, count: new_fill};
		case (state_q)
			F_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = F_UPDATE;
				end
			end
			F_UPDATE: begin
				if (!q_full) begin
					push.valid = 1'b1;
					ram_we     = 1'b1;
					state_d    = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			wl_q    <= cnt_t'(MAX_WINDOW);
			wpos_q  <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				wl_q   <= wl_d;
				wpos_q <= '0;
				fill_q <= '0;
				sum_q  <= '0;
			end else if (ram_we) begin
				wpos_q <= next_pos;
				fill_q <= new_fill;
				sum_q  <= new_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_q <= s_tdata[SAMPLE_BITS-1:0];
		end
	end

`ifndef NO_ASSERTIONS
	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= wl_q) else $error("fill count exceeds window length");
	a_pos_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_t'(wpos_q) < wl_q) else $error("write position outside window");
`endif

endmodule

// ----- sv/mwsm_fifo.sv -----
// Short queue of divide jobs between the ring update and the divider.
// Depends on mwsm_pkg.
module mwsm_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  mwsm_pkg::push_t   push,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output mwsm_pkg::job_t    head
);
	import mwsm_pkg::*;

	job_t                 mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [Q_PTR_W:0]     cnt_q;

	assign full  = (cnt_q == (Q_PTR_W + 1)'(Q_DEPTH));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + (Q_PTR_W)'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + (Q_PTR_W)'(1);
			end
			if (push.valid && !pop) begin
				cnt_q <= cnt_q + (Q_PTR_W + 1)'(1);
			end else if (pop && !push.valid) begin
				cnt_q <= cnt_q - (Q_PTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.job;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full) else $error("push into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid) else $error("pop from an empty queue");
`endif

endmodule

// ----- sv/mwsm_back.sv -----
// Back part: restoring divider for the mean and the result output register.
// Depends on mwsm_pkg; takes jobs from mwsm_fifo.
module mwsm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  mwsm_pkg::job_t      q_head,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output mwsm_pkg::result_t   result
);
	import mwsm_pkg::*;

	back_state_t      state_q, state_d;
	job_t             job_q;
	divd_t            quo_q;
	cnt_t             rem_q, rem_next;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W:0]   trial, divisor_ext;
	logic             trial_ge;
	logic             m_tvalid_q;
	result_t          result_q;
	logic             out_load;

	// One quotient bit per cycle, dividend bits shifted in from the top.
	always_comb begin
		trial       = {rem_q, quo_q[DIVD_W-1]};
		divisor_ext = {1'b0, job_q.count};
		trial_ge    = (trial >= divisor_ext);
		rem_next    = trial_ge ? CNT_W'(trial - divisor_ext) : CNT_W'(trial);
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = B_DIVIDE;
				end
			end
			B_DIVIDE: begin
				if (step_q == STEP_W'(DIVD_W - 1)) begin
					state_d = B_HOLD;
				end
			end
			B_HOLD: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q  <= q_head;
			quo_q  <= {q_head.sum, {FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			step_q <= '0;
		end else if (state_q == B_DIVIDE) begin
			quo_q  <= {quo_q[DIVD_W-2:0], trial_ge};
			rem_q  <= rem_next;
			step_q <= step_q + STEP_W'(1);
		end
		if (out_load) begin
			result_q <= '{mean: mean_t'(quo_q), count: job_q.count, sum: job_q.sum};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign result   = result_q;

`ifndef NO_ASSERTIONS
	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIVIDE) |-> (job_q.count != '0))
		else $error("divide by a zero fill count");
`endif

endmodule

// ----- sv/moving_window_sum_mean_core.sv -----
// Top level of the moving window sum and mean core.
// Depends on mwsm_pkg, mwsm_front, mwsm_fifo and mwsm_back.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata: sample_value
//   m_*      out  m_tvalid/m_tready  m_tdata: window_sum, fill_count, mean_q8
//   cfg_*    in   cfg_valid/ready    cfg_data: window_len
//
// The front takes one sample at a time: it captures the sample and reads the ring,
// then does the update, waiting while the job queue is full. The back takes one job at
// a time: it loads it, runs the bit-serial divider, then loads the output register.
// A two-entry job queue lets the front run ahead while the divider is busy.
// Reset, or a window_len write, clears the window through the fill count.
module moving_window_sum_mean_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [mwsm_pkg::S_TDATA_W-1:0]   s_tdata,  // [15:0] sample_value
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [21:0] window_sum, [28:22] fill_count, [52:29] mean_q8, rest zero
	output logic [mwsm_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mwsm_pkg::CNT_W-1:0]       cfg_data
);
	import mwsm_pkg::*;

	push_t   push;
	logic    q_full, q_valid, q_pop;
	job_t    q_head;
	result_t result;

	mwsm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.push     (push),
		.q_full   (q_full)
	);

	mwsm_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (q_full),
		.pop   (q_pop),
		.valid (q_valid),
		.head  (q_head)
	);

	mwsm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.result  (result)
	);

	assign m_tdata = M_TDATA_W'(result);

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for moving_window_sum_mean_core.
// Depends on mwsm_pkg and the core; predicts every result beat and checks it field by field.
// Window lengths from clamped to full, with random sender gaps and receiver stalls.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mwsm_pkg::*;

	localparam int RANDOM_ITEMS   = 700;
	localparam int DRAIN_CYCLES   = 48;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef enum int {
		MIX_UNIFORM,
		MIX_MAX,
		MIX_ZERO,
		MIX_SMALL,
		MIX_EXTREME,
		MIX_ONEHOT
	} sample_mix_t;

	// Tracks the window the way the core should and holds the stats still owed.
	class window_stats_sb;
		sample_t     ring[MAX_WINDOW];
		int unsigned wr_pos;
		sum_t        run_sum;
		cnt_t        filled;
		cnt_t        win_len;
		result_t     pending_stats[$];
		int unsigned mismatches;
		int unsigned checked;

		function new();
			mismatches = 0;
			checked    = 0;
			win_len    = cnt_t'(MAX_WINDOW);
			clear_window();
		endfunction

		function void clear_window();
			foreach (ring[i])
				ring[i] = '0;
			wr_pos  = 0;
			run_sum = '0;
			filled  = '0;
		endfunction

		// Zero is taken as one and anything past the ring size saturates.
		function void set_window_len(cnt_t v);
			if (v == 0)
				win_len = 1;
			else if (v > MAX_WINDOW)
				win_len = cnt_t'(MAX_WINDOW);
			else
				win_len = v;
			clear_window();
		endfunction

		function void take_sample(sample_t s);
			int unsigned   pos;
			logic [31:0]   scaled;
			logic [31:0]   quot;
			result_t       e;
			pos = wr_pos;
			if (pos >= win_len)
				pos = 0;
			run_sum   = run_sum + s - ring[pos];
			ring[pos] = s;
			wr_pos    = (pos == 0) ? win_len - 1 : pos - 1;
			if (filled < win_len)
				filled++;
			scaled = 32'(run_sum) << FRAC_BITS;
			quot   = scaled / 32'(filled);
			e.sum   = run_sum;
			e.count = filled;
			e.mean  = quot[MEAN_W-1:0];
			pending_stats.push_back(e);
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] beat);
			result_t got;
			result_t exp_r;
			got = beat[RES_W-1:0];
			checked++;
			if (pending_stats.size() == 0) begin
				$display("%0t: result beat with nothing outstanding: sum %0d count %0d mean %0d",
					$time, got.sum, got.count, got.mean);
				mismatches++;
				return;
			end
			exp_r = pending_stats.pop_front();
			if (got.sum !== exp_r.sum) begin
				$display("%0t: window_sum expected %0d, got %0d", $time, exp_r.sum, got.sum);
				mismatches++;
			end
			if (got.count !== exp_r.count) begin
				$display("%0t: fill_count expected %0d, got %0d", $time, exp_r.count, got.count);
				mismatches++;
			end
			if (got.mean !== exp_r.mean) begin
				$display("%0t: mean_q8 expected %0d, got %0d", $time, exp_r.mean, got.mean);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // [15:0] sample_value
	logic                 m_tvalid;
	logic                 m_tready;
	// [21:0] window_sum, [28:22] fill_count, [52:29] mean_q8, rest zero
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CNT_W-1:0]     cfg_data;

	window_stats_sb sb;
	int unsigned    burst_left = 0;
	int unsigned    samples_sent = 0;
	int unsigned    window_writes = 0;
	int unsigned    idle_cycles = 0;
	logic [15:0]    ready_pattern = '1;
	int unsigned    ready_phase = 0;

	moving_window_sum_mean_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The receiver walks a 16-bit ready pattern, and a new pattern is drawn each time the phase counter's low byte wraps.
	always @(posedge clk) begin
		ready_phase <= ready_phase + 1;
		if (ready_phase[7:0] == 8'd0) begin
			if ($urandom_range(0, 3) == 0)
				ready_pattern <= '1;
			else
				ready_pattern <= 16'($urandom) | 16'h0001;
		end
		m_tready <= ready_pattern[ready_phase[3:0]];
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.take_sample(s_tdata[SAMPLE_BITS-1:0]);
		if (arst_n && cfg_valid && cfg_ready)
			sb.set_window_len(cfg_data);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat on any channel for %0d cycles", $time, idle_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// The sender runs in bursts; a gap of random length may open before each burst.
	task automatic send_sample(sample_t v);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_W'(v);
		do @(posedge clk); while (!s_tready);
		burst_left--;
		samples_sent++;
	endtask

	// The window may only change once every result owed has come back.
	task automatic write_window_len(cnt_t v);
		s_tvalid <= 1'b0;
		while (sb.pending_stats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		window_writes++;
	endtask

	function automatic sample_t pick_sample(sample_mix_t mix);
		case (mix)
			MIX_MAX:     return '1;
			MIX_ZERO:    return '0;
			MIX_SMALL:   return sample_t'($urandom_range(0, 15));
			MIX_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
			MIX_ONEHOT:  return sample_t'(1) << $urandom_range(0, SAMPLE_BITS - 1);
			default:     return sample_t'($urandom);
		endcase
	endfunction

	initial begin
		int unsigned n;
		int unsigned w_eff;
		cnt_t        w_req;
		sample_mix_t mix;

		sb = new();
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset window of full length.
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'hFFFF);
		send_sample(16'h0001);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'hAAAA);
		send_sample(16'h5555);

		// A zero length acts as a one-sample window.
		write_window_len(cnt_t'(0));
		send_sample(16'hFFFF);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'h3039);

		write_window_len(cnt_t'(2));
		send_sample(16'hFFFF);
		send_sample(16'hFFFF);
		send_sample(16'hFFFF);
		send_sample(16'h0000);
		send_sample(16'h0001);

		// Oversized lengths saturate; writing the same value again still clears.
		write_window_len(cnt_t'(127));
		send_sample(16'h1234);
		send_sample(16'hFEDC);
		write_window_len(cnt_t'(65));
		send_sample(16'h00FF);
		write_window_len(cnt_t'(65));
		send_sample(16'hFF00);
		send_sample(16'h0F0F);
		write_window_len(cnt_t'(1));
		send_sample(16'hFFFF);

		n = samples_sent + RANDOM_ITEMS;
		while (samples_sent < n) begin
			case ($urandom_range(0, 7))
				0:       w_req = cnt_t'(0);
				1:       w_req = cnt_t'(1);
				2:       w_req = cnt_t'(64);
				3:       w_req = cnt_t'($urandom_range(65, 127));
				4:       w_req = cnt_t'($urandom_range(2, 4));
				default: w_req = cnt_t'($urandom_range(0, 127));
			endcase
			w_eff = (w_req == 0) ? 1 : ((w_req > MAX_WINDOW) ? MAX_WINDOW : w_req);
			write_window_len(w_req);
			mix = ($urandom_range(0, 1) == 0) ? MIX_UNIFORM
				: sample_mix_t'($urandom_range(MIX_UNIFORM, MIX_ONEHOT));
			// A run of full-scale samples is made long enough to fill the window.
			if (mix == MIX_MAX)
				w_eff = w_eff + $urandom_range(1, 20);
			else
				w_eff = $urandom_range(1, 3 * w_eff + 4);
			repeat (w_eff)
				send_sample(pick_sample(mix));
		end
		s_tvalid <= 1'b0;

		while (sb.pending_stats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d samples across %0d window_len writes (0, 1, small, 64 and oversized).",
			samples_sent, window_writes);
		$display("Checked %0d result beats, %0d field mismatches, %0d results outstanding.",
			sb.checked, sb.mismatches, sb.pending_stats.size());
		if (sb.mismatches == 0 && sb.pending_stats.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/mwsm_pkg.sv
sv/mwsm_ram.sv
sv/mwsm_front.sv
sv/mwsm_fifo.sv
sv/mwsm_back.sv
sv/moving_window_sum_mean_core.sv
verif/tb.sv
